// ===== rtl/core/desq_pkg.sv =====
`default_nettype none

package desq_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int MODE_BITS   = 3;
    localparam int STATUS_BITS = 2;
    localparam int PORT_VALUE_BITS = 32;
    localparam int PORT_COUNT_BITS = 7;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PUSH_FRONT   = 3'd0,
        MODE_PUSH_BACK    = 3'd1,
        MODE_POP_FRONT    = 3'd2,
        MODE_POP_BACK     = 3'd3,
        MODE_REMOVE_FIRST = 3'd4,
        MODE_REMOVE_ALL   = 3'd5,
        MODE_EXISTS       = 3'd6,
        MODE_CLEAR        = 3'd7
    } mode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RD_FRONT,
        ST_RD_BACK,
        ST_DELIVER
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/double_ended_queue_with_search_unit.sv =====
`default_nettype none

// Double-ended queue of signed values kept in a ring buffer of CAPACITY entries in one
// single-port-read RAM. Each transfer on the s_ channel carries one operation (push or pop
// at either end, remove first match, remove all matches with compaction, membership test,
// clear) and produces exactly one transfer on the m_ channel with status, found flag, front
// and back values, entry count and removed count. s_ready is high only while the sequencer
// is idle. Push, pop and clear pass through EXEC, RD_FRONT, RD_BACK and DELIVER; the three
// search modes add a SCAN state after EXEC, which reads the RAM through its one read port
// at one entry per cycle while compaction writes kept entries back through the write port.
// A result waiting in the output register holds off DELIVER but not the next acceptance.
module double_ended_queue_with_search_unit
    import desq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic        [MODE_BITS-1:0]       s_mode,
    input  wire logic signed [PORT_VALUE_BITS-1:0] s_item_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic             [STATUS_BITS-1:0]     m_status,
    output logic                                   m_found,
    output logic signed      [PORT_VALUE_BITS-1:0] m_front_value,
    output logic signed      [PORT_VALUE_BITS-1:0] m_back_value,
    output logic             [PORT_COUNT_BITS-1:0] m_entry_total,
    output logic             [PORT_COUNT_BITS-1:0] m_removed_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Ring slot of a logical position; both operands are below CAPACITY.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= CAP_SUM) begin
            sum = sum - CAP_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] narrow_value(
        input logic [PORT_VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] r;
        for (int i = 0; i < VALUE_BITS; i++) begin
            r[i] = (i < PORT_VALUE_BITS) ? v[i] : v[PORT_VALUE_BITS-1];
        end
        return r;
    endfunction

    function automatic logic [PORT_VALUE_BITS-1:0] port_value(
        input logic [VALUE_BITS-1:0] v);
        logic [PORT_VALUE_BITS-1:0] r;
        for (int i = 0; i < PORT_VALUE_BITS; i++) begin
            r[i] = (i < VALUE_BITS) ? v[i] : v[VALUE_BITS-1];
        end
        return r;
    endfunction

    function automatic logic [PORT_COUNT_BITS-1:0] port_count(input logic [CNT_W-1:0] c);
        logic [PORT_COUNT_BITS-1:0] r;
        for (int i = 0; i < PORT_COUNT_BITS; i++) begin
            r[i] = (i < CNT_W) ? c[i] : 1'b0;
        end
        return r;
    endfunction

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    mode_t                 mode_reg, mode_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      keep_reg, keep_next;
    logic [CNT_W-1:0]      removed_reg, removed_next;
    logic                  hit_reg, hit_next;
    status_t               status_reg, status_next;
    logic [VALUE_BITS-1:0] front_tmp_reg, front_tmp_next;

    logic                       m_valid_reg, m_valid_next;
    logic [STATUS_BITS-1:0]     m_status_reg, m_status_next;
    logic                       m_found_reg, m_found_next;
    logic [PORT_VALUE_BITS-1:0] m_front_reg, m_front_next;
    logic [PORT_VALUE_BITS-1:0] m_back_reg, m_back_next;
    logic [PORT_COUNT_BITS-1:0] m_total_reg, m_total_next;
    logic [PORT_COUNT_BITS-1:0] m_removed_reg, m_removed_next;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    logic             s_fire;
    logic             out_free;
    logic             is_full;
    logic             is_remove;
    logic             elem_match;
    logic             scan_last;
    logic [IDX_W-1:0] back_slot;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [CNT_W-1:0] occ_dec;

    desq_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign is_full    = (occ_reg == CAP_CNT);
    assign is_remove  = (mode_reg == MODE_REMOVE_FIRST) || (mode_reg == MODE_REMOVE_ALL);
    assign elem_match = (rd_data == val_reg);
    assign scan_last  = (pos_reg == total_reg);
    assign occ_dec    = occ_reg - CNT_ONE;
    assign back_slot  = slot_of(front_reg, occ_dec[IDX_W-1:0]);
    assign front_dec  = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign front_inc  = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if ((mode_reg == MODE_REMOVE_FIRST) || (mode_reg == MODE_REMOVE_ALL) ||
                    (mode_reg == MODE_EXISTS)) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_RD_FRONT;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_RD_FRONT;
                end
            end
            ST_RD_FRONT: state_next = ST_RD_BACK;
            ST_RD_BACK:  state_next = ST_DELIVER;
            ST_DELIVER: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        front_next     = front_reg;
        occ_next       = occ_reg;
        mode_next      = mode_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        keep_next      = keep_reg;
        removed_next   = removed_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        front_tmp_next = front_tmp_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_of(front_reg, keep_reg[IDX_W-1:0]);
        wr_data        = rd_data;
        rd_addr        = back_slot;

        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_found_next   = m_found_reg;
        m_front_next   = m_front_reg;
        m_back_next    = m_back_reg;
        m_total_next   = m_total_reg;
        m_removed_next = m_removed_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    mode_next = mode_t'(s_mode);
                    val_next  = narrow_value(s_item_value);
                end
            end
            ST_EXEC: begin
                hit_next     = 1'b0;
                removed_next = '0;
                status_next  = STATUS_OK;
                pos_next     = '0;
                keep_next    = '0;
                total_next   = occ_reg;
                case (mode_reg)
                    MODE_PUSH_FRONT: begin
                        if (is_full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = front_dec;
                            wr_data    = val_reg;
                            front_next = front_dec;
                            occ_next   = occ_reg + CNT_ONE;
                        end
                    end
                    MODE_PUSH_BACK: begin
                        if (is_full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            wr_en    = 1'b1;
                            wr_addr  = slot_of(front_reg, occ_reg[IDX_W-1:0]);
                            wr_data  = val_reg;
                            occ_next = occ_reg + CNT_ONE;
                        end
                    end
                    MODE_POP_FRONT: begin
                        if (occ_reg == '0) begin
                            status_next = STATUS_EMPTY;
                        end else begin
                            front_next   = front_inc;
                            occ_next     = occ_dec;
                            removed_next = CNT_ONE;
                        end
                    end
                    MODE_POP_BACK: begin
                        if (occ_reg == '0) begin
                            status_next = STATUS_EMPTY;
                        end else begin
                            occ_next     = occ_dec;
                            removed_next = CNT_ONE;
                        end
                    end
                    MODE_CLEAR: begin
                        removed_next = occ_reg;
                        occ_next     = '0;
                        front_next   = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                // A read is issued for position pos while the data of position pos-1
                // is judged; kept entries are written back at position keep, which
                // never passes the read pointer.
                rd_addr = slot_of(front_reg, pos_reg[IDX_W-1:0]);
                if (pos_reg != '0) begin
                    hit_next = hit_reg || elem_match;
                    if (elem_match && ((mode_reg == MODE_REMOVE_ALL) ||
                        ((mode_reg == MODE_REMOVE_FIRST) && (removed_reg == '0)))) begin
                        removed_next = removed_reg + CNT_ONE;
                    end else if (is_remove) begin
                        wr_en     = 1'b1;
                        keep_next = keep_reg + CNT_ONE;
                    end
                end
                if (scan_last) begin
                    status_next = hit_next ? STATUS_OK : STATUS_NOT_FOUND;
                    if (is_remove) begin
                        occ_next = keep_next;
                    end
                end else begin
                    pos_next = pos_reg + CNT_ONE;
                end
            end
            ST_RD_FRONT: begin
                rd_addr = front_reg;
            end
            ST_RD_BACK: begin
                front_tmp_next = rd_data;
            end
            ST_DELIVER: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_found_next   = hit_reg;
                    m_front_next   = (occ_reg == '0) ? '0 : port_value(front_tmp_reg);
                    m_back_next    = (occ_reg == '0) ? '0 : port_value(rd_data);
                    m_total_next   = port_count(occ_reg);
                    m_removed_next = port_count(removed_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        total_reg     <= total_next;
        keep_reg      <= keep_next;
        removed_reg   <= removed_next;
        hit_reg       <= hit_next;
        status_reg    <= status_next;
        front_tmp_reg <= front_tmp_next;
        m_status_reg  <= m_status_next;
        m_found_reg   <= m_found_next;
        m_front_reg   <= m_front_next;
        m_back_reg    <= m_back_next;
        m_total_reg   <= m_total_next;
        m_removed_reg <= m_removed_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found         = m_found_reg;
    assign m_front_value   = m_front_reg;
    assign m_back_value    = m_back_reg;
    assign m_entry_total   = m_total_reg;
    assign m_removed_count = m_removed_reg;

endmodule

`default_nettype wire

// ===== rtl/core/desq_ram.sv =====
`default_nettype none

module desq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== tb/double_ended_queue_with_search_unit_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_with_search_unit_tb;
    import desq_pkg::*;

    localparam int DEPTH = DEF_CAPACITY;
    localparam int ITEM_GOAL = 1850;

    typedef struct {
        status_t                              status;
        logic                                 found;
        logic signed [PORT_VALUE_BITS-1:0]    front;
        logic signed [PORT_VALUE_BITS-1:0]    back;
        logic        [PORT_COUNT_BITS-1:0]    total;
        logic        [PORT_COUNT_BITS-1:0]    removed;
    } reply_t;

    // Tracks the deque contents and the replies still owed by the block.
    class deque_scoreboard;
        logic signed [PORT_VALUE_BITS-1:0] ring [DEPTH];
        int unsigned head;
        int unsigned fill;
        reply_t      owed_replies [$];
        int          errors;

        function new();
            head = 0;
            fill = 0;
            errors = 0;
        endfunction

        function int unsigned at(int unsigned pos);
            return (head + pos) % DEPTH;
        endfunction

        function int outstanding();
            return owed_replies.size();
        endfunction

        // A value currently held (a random one when empty), so that searches can hit.
        function logic signed [PORT_VALUE_BITS-1:0] pick_stored();
            if (fill == 0) return $urandom;
            return ring[at($urandom_range(0, fill - 1))];
        endfunction

        function void note_request(mode_t mode, logic signed [PORT_VALUE_BITS-1:0] value);
            reply_t      r;
            int unsigned i;
            int unsigned j;
            int unsigned keep;
            int unsigned total;
            logic signed [PORT_VALUE_BITS-1:0] e;
            r.status = STATUS_OK;
            r.found = 1'b0;
            r.removed = '0;
            case (mode)
                MODE_PUSH_FRONT: begin
                    if (fill >= DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = value;
                        fill++;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        ring[at(fill)] = value;
                        fill++;
                    end
                end
                MODE_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        head = (head + 1) % DEPTH;
                        fill--;
                        r.removed = PORT_COUNT_BITS'(1);
                    end
                end
                MODE_POP_BACK: begin
                    if (fill == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        fill--;
                        r.removed = PORT_COUNT_BITS'(1);
                    end
                end
                MODE_REMOVE_FIRST: begin
                    for (i = 0; i < fill && !r.found; i++) begin
                        if (ring[at(i)] == value) begin
                            for (j = i; j + 1 < fill; j++) ring[at(j)] = ring[at(j + 1)];
                            fill--;
                            r.found = 1'b1;
                            r.removed = PORT_COUNT_BITS'(1);
                        end
                    end
                    r.status = r.found ? STATUS_OK : STATUS_NOT_FOUND;
                end
                MODE_REMOVE_ALL: begin
                    // Kept entries slide toward the front in their original order.
                    keep = 0;
                    total = fill;
                    for (i = 0; i < total; i++) begin
                        e = ring[at(i)];
                        if (e == value) begin
                            r.removed++;
                        end else begin
                            ring[at(keep)] = e;
                            keep++;
                        end
                    end
                    fill = keep;
                    r.found = (r.removed != 0);
                    r.status = r.found ? STATUS_OK : STATUS_NOT_FOUND;
                end
                MODE_EXISTS: begin
                    for (i = 0; i < fill; i++) begin
                        if (ring[at(i)] == value) r.found = 1'b1;
                    end
                    r.status = r.found ? STATUS_OK : STATUS_NOT_FOUND;
                end
                default: begin
                    r.removed = PORT_COUNT_BITS'(fill);
                    fill = 0;
                    head = 0;
                end
            endcase
            r.front = (fill != 0) ? ring[head] : '0;
            r.back = (fill != 0) ? ring[at(fill - 1)] : '0;
            r.total = PORT_COUNT_BITS'(fill);
            owed_replies.push_back(r);
        endfunction

        function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        function void check_result(logic [STATUS_BITS-1:0] status, logic found,
                                   logic signed [PORT_VALUE_BITS-1:0] front,
                                   logic signed [PORT_VALUE_BITS-1:0] back,
                                   logic [PORT_COUNT_BITS-1:0] total,
                                   logic [PORT_COUNT_BITS-1:0] removed);
            reply_t r;
            if (owed_replies.size() == 0) begin
                errors++;
                $error("result transfer with no request outstanding");
                return;
            end
            r = owed_replies.pop_front();
            compare("status", r.status, status);
            compare("found", r.found, found);
            compare("front_value", r.front, front);
            compare("back_value", r.back, back);
            compare("entry_total", r.total, total);
            compare("removed_count", r.removed, removed);
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic        [MODE_BITS-1:0]         s_mode;
    logic signed [PORT_VALUE_BITS-1:0]   s_item_value;
    logic                                m_valid;
    logic                                m_ready;
    logic        [STATUS_BITS-1:0]       m_status;
    logic                                m_found;
    logic signed [PORT_VALUE_BITS-1:0]   m_front_value;
    logic signed [PORT_VALUE_BITS-1:0]   m_back_value;
    logic        [PORT_COUNT_BITS-1:0]   m_entry_total;
    logic        [PORT_COUNT_BITS-1:0]   m_removed_count;

    deque_scoreboard sb;
    int  issued;
    int  burst_left;
    bit  hold_off_req;

    double_ended_queue_with_search_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_item_value    (s_item_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found         (m_found),
        .m_front_value   (m_front_value),
        .m_back_value    (m_back_value),
        .m_entry_total   (m_entry_total),
        .m_removed_count (m_removed_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Offers one request, waits for the edge where the transfer happens, then applies pacing.
    task automatic send(input mode_t mode, input logic signed [PORT_VALUE_BITS-1:0] value);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_item_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(mode, value);
        issued++;
        pace();
    endtask

    // Mostly a small pool of values so that searches and duplicates happen often.
    function automatic logic signed [PORT_VALUE_BITS-1:0] draw_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return $urandom;
        if (pick == 2) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 0;
                default: return -1;
            endcase
        end
        return $signed($urandom_range(0, 7)) - 4;
    endfunction

    task automatic run_fill(input int n);
        repeat (n) begin
            send($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, draw_value());
        end
    endtask

    task automatic run_drain(input int n);
        repeat (n) begin
            send($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT, draw_value());
        end
    endtask

    task automatic run_search(input int n);
        logic signed [PORT_VALUE_BITS-1:0] v;
        int op;
        repeat (n) begin
            v = ($urandom_range(0, 9) < 6) ? sb.pick_stored() : draw_value();
            op = $urandom_range(0, 9);
            if (op < 3) send(MODE_REMOVE_FIRST, v);
            else if (op < 5) send(MODE_REMOVE_ALL, v);
            else if (op < 8) send(MODE_EXISTS, v);
            else send($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, v);
        end
    endtask

    task automatic run_noise(input int n);
        repeat (n) begin
            send(mode_t'($urandom_range(0, 7)), $urandom);
        end
    endtask

    initial begin
        int choice;
        sb = new();
        issued = 0;
        burst_left = 1;
        hold_off_req = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_mode <= MODE_PUSH_FRONT;
        s_item_value <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty store: pops fail and every search misses.
        send(MODE_POP_FRONT, 0);
        send(MODE_POP_BACK, 0);
        send(MODE_REMOVE_FIRST, 5);
        send(MODE_REMOVE_ALL, 5);
        send(MODE_EXISTS, 5);
        send(MODE_PUSH_BACK, 32'sh7fff_ffff);
        send(MODE_PUSH_FRONT, 32'sh8000_0000);
        send(MODE_PUSH_BACK, -1);
        send(MODE_PUSH_FRONT, 0);
        send(MODE_EXISTS, -1);
        send(MODE_EXISTS, 12345);
        send(MODE_PUSH_BACK, -1);
        send(MODE_PUSH_FRONT, -1);
        // Three matches spread over the store; survivors must keep their order.
        send(MODE_REMOVE_ALL, -1);
        send(MODE_REMOVE_FIRST, 32'sh8000_0000);
        send(MODE_REMOVE_FIRST, 32'sh7fff_ffff);
        send(MODE_POP_BACK, 0);
        send(MODE_PUSH_FRONT, 32'sh5a5a_5a5a);
        send(MODE_REMOVE_FIRST, 32'sh5a5a_5a5a);
        send(MODE_PUSH_BACK, 7);
        send(MODE_PUSH_BACK, 7);
        send(MODE_CLEAR, 0);
        send(MODE_PUSH_FRONT, 9);
        send(MODE_POP_FRONT, 0);

        // Overfill once so that pushes on a full store are seen early.
        run_fill(DEPTH + 4);
        while (issued < ITEM_GOAL) begin
            if (issued > 600 && issued < 700) hold_off_req = 1'b1;
            choice = $urandom_range(0, 19);
            if (choice < 6) run_fill($urandom_range(10, 70));
            else if (choice < 12) run_search($urandom_range(10, 30));
            else if (choice < 16) run_drain($urandom_range(5, 40));
            else if (choice < 19) run_noise($urandom_range(3, 12));
            else send(MODE_CLEAR, $urandom);
        end

        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Result side: checks each transfer and stalls on a pattern that shifts as the cycle counter advances.
    initial begin
        int cyc;
        int hold_left;
        int busy_pct;
        cyc = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_status, m_found, m_front_value, m_back_value,
                                m_entry_total, m_removed_count);
            end
            cyc++;
            case ((cyc >> 8) % 4)
                0: busy_pct = 0;
                1: busy_pct = 25;
                2: busy_pct = 50;
                default: busy_pct = 85;
            endcase
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_off_req) begin
                // Long hold-off so that the block backs up and stalls its input.
                hold_off_req = 1'b0;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= busy_pct);
            end
        end
    end

endmodule

// ===== sim.f =====
rtl/core/desq_pkg.sv
rtl/core/desq_ram.sv
rtl/core/double_ended_queue_with_search_unit.sv
tb/double_ended_queue_with_search_unit_tb.sv
